/* sv/kmer_coverage_min_sd_window_defines.svh */
// ----------------------------------------------------------------------------
// kmer coverage min sd window assertion macros
// assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef KMER_COVERAGE_MIN_SD_WINDOW_DEFINES_SVH
`define KMER_COVERAGE_MIN_SD_WINDOW_DEFINES_SVH
`ifndef SYNTH
// clocked assertion, off while reset is low
`define KCMSW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion, also checked during reset
`define KCMSW_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCMSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCMSW_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* sv/kcmsw_pkg.sv */
// ----------------------------------------------------------------------------
// kcmsw package
// widths, register decode and controller/datapath interface types
// ----------------------------------------------------------------------------
package kcmsw_pkg;

  localparam int IDX_W   = 6;   // positions, counts, window lengths
  localparam int CNT_W   = 24;  // one kmer count
  localparam int KLEN_W  = 6;
  localparam int SUM_W   = 30;  // sum of up to 63 counts
  localparam int SQS_W   = 54;  // sum of squares
  localparam int PROD_W  = 60;
  localparam int DEN_W   = 12;  // len * len
  localparam int REM_W   = DEN_W + 1;
  localparam int DVD_W   = PROD_W + 16;
  localparam int DIVC_W  = 7;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int SQC_W   = 6;
  localparam int MEAN_W  = 32;
  localparam int OUT_W   = 80;

  localparam logic [IDX_W-1:0] MAX_K = 6'd32;

  // paddr[2] selects the register word
  localparam logic REG_KMER_LENGTH = 1'b0;

  typedef struct packed {
    logic load;
    logic pos_first;
    logic pos_next;
    logic win_first;
    logic win_next;
    logic acc_init;
    logic acc_init_fb;
    logic acc;
    logic mul;
    logic sub;
    logic div_mean;
    logic div_var;
    logic take_mean;
    logic take_var;
    logic cmp;
    logic emit_pos;
    logic fb_sum;
    logic emit_sum;
    logic clear_run;
  } cmd_t;

  typedef struct packed {
    logic covers;
    logic acc_last;
    logic div_busy;
    logic sq_busy;
    logic s_at_p;
    logic p_at_end;
    logic out_busy;
  } sts_t;

endpackage

/* sv/kcmsw_ram.sv */
// ----------------------------------------------------------------------------
// kcmsw ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module kcmsw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/kcmsw_datapath.sv */
// ----------------------------------------------------------------------------
// kcmsw datapath
// count store, window accumulators, serial divider, serial square root
// ----------------------------------------------------------------------------
module kcmsw_datapath #(
  parameter int MAX_COUNTS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kcmsw_pkg::cmd_t               cmd_i,
  output kcmsw_pkg::sts_t               sts_o,
  input  logic [kcmsw_pkg::CNT_W-1:0]   count_i,
  input  logic [1:0]                    flags_i,
  input  logic [kcmsw_pkg::KLEN_W-1:0]  kmer_length_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [kcmsw_pkg::OUT_W-1:0]   m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);
  import kcmsw_pkg::*;

  localparam int AW = (MAX_COUNTS > 1) ? $clog2(MAX_COUNTS) : 1;

  logic [IDX_W-1:0]  n_q, p_q, s_q, i_q, base_q, len_q;
  logic [1:0]        flags_q;
  logic              first_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQS_W-1:0]  sumsq_q;
  logic [PROD_W-1:0] prod1_q, prod2_q, num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DVD_W-1:0]  div_dq_q;
  logic [REM_W-1:0]  div_rem_q;
  logic [DEN_W-1:0]  div_den_q;
  logic [DIVC_W-1:0] div_cnt_q;
  logic [RAD_W-1:0]  sq_x_q;
  logic [ROOT_W+2:0] sq_rem_q;
  logic [ROOT_W-1:0] sq_root_q;
  logic [SQC_W-1:0]  sq_cnt_q;
  logic [MEAN_W-1:0] mean_q;
  logic [IDX_W-1:0]  best_start_q;
  logic [MEAN_W-1:0] best_mean_q, best_sd_q;
  logic [IDX_W-1:0]  sum_pos_q, sum_start_q;
  logic [MEAN_W-1:0] sum_mean_q, sum_sd_q;
  logic              out_valid_q, out_summ_q;
  logic [OUT_W-1:0]  out_data_q;

  logic [IDX_W-1:0]  k_eff, head, tail, lo, p_end, win_len;
  logic [IDX_W:0]    p1, m1, rem_n;
  logic [CNT_W-1:0]  rd_data;
  logic [2*CNT_W-1:0] c_sq;
  logic [REM_W-1:0]  div_t;
  logic              div_ge;
  logic [ROOT_W+2:0] sq_t, sq_trial;
  logic              sq_ge;
  logic              store_we;
  logic [IDX_W-1:0]  raddr;

  // effective k and trims
  always_comb begin
    if (kmer_length_i == '0) begin
      k_eff = IDX_W'(1);
    end else if (kmer_length_i > MAX_K) begin
      k_eff = MAX_K;
    end else begin
      k_eff = kmer_length_i;
    end
    head  = flags_q[0] ? k_eff - IDX_W'(1) : '0;
    tail  = flags_q[1] ? k_eff : '0;
    p_end = n_q - tail - IDX_W'(1);
    p1    = {1'b0, p_q} + (IDX_W+1)'(1);
    lo    = (p1 > {1'b0, k_eff}) ? IDX_W'(p1 - {1'b0, k_eff}) : '0;
    m1    = (p1 < {1'b0, k_eff}) ? p1 : {1'b0, k_eff};
    rem_n = {1'b0, n_q} - {1'b0, s_q};
    win_len = (m1 < rem_n) ? IDX_W'(m1) : IDX_W'(rem_n);
  end

  assign sts_o.covers   = ({1'b0, n_q} <= ({1'b0, head} + {1'b0, tail}));
  assign sts_o.acc_last = (i_q == len_q - IDX_W'(1));
  assign sts_o.div_busy = (div_cnt_q != '0);
  assign sts_o.sq_busy  = (sq_cnt_q != '0);
  assign sts_o.s_at_p   = (s_q == p_q);
  assign sts_o.p_at_end = (p_q == p_end);
  assign sts_o.out_busy = out_valid_q;

  assign store_we = cmd_i.load && (n_q < IDX_W'(MAX_COUNTS));
  assign raddr    = base_q + i_q;

  kcmsw_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_COUNTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (count_i),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign c_sq = rd_data * rd_data;

  // restoring divider step
  assign div_t  = {div_rem_q[REM_W-2:0], div_dq_q[DVD_W-1]};
  assign div_ge = (div_t >= {1'b0, div_den_q});

  // digit-by-digit square root step
  assign sq_t     = {sq_rem_q[ROOT_W:0], sq_x_q[RAD_W-1:RAD_W-2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  // loop control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      flags_q     <= '0;
      p_q         <= '0;
      s_q         <= '0;
      i_q         <= '0;
      first_q     <= 1'b0;
      div_cnt_q   <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      sum_pos_q   <= '0;
      sum_start_q <= '0;
      sum_mean_q  <= '1;
      sum_sd_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        if (n_q == '0) begin
          flags_q <= flags_i;
        end
        if (store_we) begin
          n_q <= n_q + IDX_W'(1);
        end
      end
      if (cmd_i.pos_first) p_q <= head;
      if (cmd_i.pos_next)  p_q <= p_q + IDX_W'(1);
      if (cmd_i.win_first) begin
        s_q     <= lo;
        first_q <= 1'b1;
      end
      if (cmd_i.win_next) s_q <= s_q + IDX_W'(1);
      if (cmd_i.acc_init || cmd_i.acc_init_fb) i_q <= '0;
      if (cmd_i.acc) i_q <= i_q + IDX_W'(1);
      if (cmd_i.cmp) first_q <= 1'b0;
      if (cmd_i.div_mean || cmd_i.div_var) begin
        div_cnt_q <= DIVC_W'(DVD_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DIVC_W'(1);
      end
      if (cmd_i.take_var) begin
        sq_cnt_q <= SQC_W'(ROOT_W);
      end else if (sq_cnt_q != '0) begin
        sq_cnt_q <= sq_cnt_q - SQC_W'(1);
      end
      if (cmd_i.emit_pos && (best_mean_q < sum_mean_q)) begin
        sum_pos_q   <= p_q;
        sum_start_q <= best_start_q;
        sum_mean_q  <= best_mean_q;
        sum_sd_q    <= best_sd_q;
      end
      if (cmd_i.fb_sum) begin
        sum_pos_q   <= '0;
        sum_start_q <= '0;
        sum_mean_q  <= mean_q;
        sum_sd_q    <= '0;
      end
      if (cmd_i.emit_pos || cmd_i.emit_sum) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear_run) begin
        n_q         <= '0;
        flags_q     <= '0;
        sum_pos_q   <= '0;
        sum_start_q <= '0;
        sum_mean_q  <= '1;
        sum_sd_q    <= '0;
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      base_q  <= s_q;
      len_q   <= win_len;
      sum_q   <= '0;
      sumsq_q <= '0;
    end
    if (cmd_i.acc_init_fb) begin
      base_q  <= '0;
      len_q   <= n_q;
      sum_q   <= '0;
      sumsq_q <= '0;
    end
    if (cmd_i.acc) begin
      sum_q   <= sum_q + SUM_W'(rd_data);
      sumsq_q <= sumsq_q + SQS_W'(c_sq);
    end
    if (cmd_i.mul) begin
      prod1_q <= PROD_W'(len_q) * sumsq_q;
      prod2_q <= PROD_W'(sum_q) * PROD_W'(sum_q);
      den_q   <= DEN_W'(len_q) * DEN_W'(len_q);
    end
    if (cmd_i.sub) num_q <= prod1_q - prod2_q;
    if (cmd_i.div_mean) begin
      div_dq_q  <= DVD_W'({sum_q, 8'b0});
      div_den_q <= DEN_W'(len_q);
      div_rem_q <= '0;
    end else if (cmd_i.div_var) begin
      div_dq_q  <= {num_q, 16'b0};
      div_den_q <= den_q;
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= div_ge ? div_t - {1'b0, div_den_q} : div_t;
      div_dq_q  <= {div_dq_q[DVD_W-2:0], div_ge};
    end
    if (cmd_i.take_mean) mean_q <= div_dq_q[MEAN_W-1:0];
    if (cmd_i.take_var) begin
      sq_x_q    <= div_dq_q[RAD_W-1:0];
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_cnt_q != '0) begin
      sq_rem_q  <= sq_ge ? sq_t - sq_trial : sq_t;
      sq_root_q <= {sq_root_q[ROOT_W-2:0], sq_ge};
      sq_x_q    <= {sq_x_q[RAD_W-3:0], 2'b00};
    end
    if (cmd_i.cmp && (first_q || (sq_root_q < best_sd_q))) begin
      best_start_q <= s_q;
      best_mean_q  <= mean_q;
      best_sd_q    <= sq_root_q;
    end
    if (cmd_i.emit_pos) begin
      out_data_q <= {4'b0, best_sd_q, best_mean_q, best_start_q, p_q};
      out_summ_q <= 1'b0;
    end
    if (cmd_i.emit_sum) begin
      out_data_q <= {4'b0, sum_sd_q, sum_mean_q, sum_start_q, sum_pos_q};
      out_summ_q <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_summ_q;
  assign m_tlast_o  = out_summ_q;

endmodule

/* sv/kcmsw_ctrl.sv */
// ----------------------------------------------------------------------------
// kcmsw controller
// sequences loading, the window walk, the arithmetic units and output
// ----------------------------------------------------------------------------
module kcmsw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            s_tlast_i,
  output logic            s_tready_o,
  input  kcmsw_pkg::sts_t sts_i,
  output kcmsw_pkg::cmd_t cmd_o
);
  import kcmsw_pkg::*;

  localparam logic [4:0] ST_LOAD   = 5'd0;
  localparam logic [4:0] ST_SETUP  = 5'd1;
  localparam logic [4:0] ST_POS    = 5'd2;
  localparam logic [4:0] ST_WIN    = 5'd3;
  localparam logic [4:0] ST_RD     = 5'd4;
  localparam logic [4:0] ST_ACC    = 5'd5;
  localparam logic [4:0] ST_MUL    = 5'd6;
  localparam logic [4:0] ST_SUB    = 5'd7;
  localparam logic [4:0] ST_DIVM   = 5'd8;
  localparam logic [4:0] ST_DIVM_W = 5'd9;
  localparam logic [4:0] ST_DIVV   = 5'd10;
  localparam logic [4:0] ST_DIVV_W = 5'd11;
  localparam logic [4:0] ST_SQ_W   = 5'd12;
  localparam logic [4:0] ST_CMP    = 5'd13;
  localparam logic [4:0] ST_EMIT   = 5'd14;
  localparam logic [4:0] ST_EMIT_W = 5'd15;
  localparam logic [4:0] ST_FBSET  = 5'd16;
  localparam logic [4:0] ST_SUM    = 5'd17;
  localparam logic [4:0] ST_SUM_W  = 5'd18;

  logic [4:0] state_q, state_d;
  logic       fb_q, fb_d;

  assign s_tready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    fb_d    = fb_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (s_tlast_i) state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts_i.covers) begin
          fb_d              = 1'b1;
          cmd_o.acc_init_fb = 1'b1;
          state_d           = ST_RD;
        end else begin
          fb_d            = 1'b0;
          cmd_o.pos_first = 1'b1;
          state_d         = ST_POS;
        end
      end
      ST_POS: begin
        cmd_o.win_first = 1'b1;
        state_d         = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.acc_init = 1'b1;
        state_d        = ST_RD;
      end
      ST_RD: state_d = ST_ACC;
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.acc_last ? ST_MUL : ST_RD;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_DIVM;
      end
      ST_DIVM: begin
        cmd_o.div_mean = 1'b1;
        state_d        = ST_DIVM_W;
      end
      ST_DIVM_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_mean = 1'b1;
          state_d         = fb_q ? ST_FBSET : ST_DIVV;
        end
      end
      ST_DIVV: begin
        cmd_o.div_var = 1'b1;
        state_d       = ST_DIVV_W;
      end
      ST_DIVV_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_var = 1'b1;
          state_d        = ST_SQ_W;
        end
      end
      ST_SQ_W: begin
        if (!sts_i.sq_busy) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.s_at_p) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.win_next = 1'b1;
          state_d        = ST_WIN;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_pos = 1'b1;
        state_d        = ST_EMIT_W;
      end
      ST_EMIT_W: begin
        if (!sts_i.out_busy) begin
          if (sts_i.p_at_end) begin
            state_d = ST_SUM;
          end else begin
            cmd_o.pos_next = 1'b1;
            state_d        = ST_POS;
          end
        end
      end
      ST_FBSET: begin
        cmd_o.fb_sum = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.emit_sum = 1'b1;
        state_d        = ST_SUM_W;
      end
      ST_SUM_W: begin
        if (!sts_i.out_busy) begin
          cmd_o.clear_run = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fb_q    <= fb_d;
    end
  end

endmodule

/* sv/kmer_coverage_min_sd_window.sv */
// ----------------------------------------------------------------------------
// kmer coverage min sd window: one count beat per cycle while loading
// after tlast each window of length len is accumulated, then processed by
// the bit-serial divider (76 steps, used for mean and variance) and sqrt
// reset clears controller, counts, trims, summary and kmer_length (to 31)
// ----------------------------------------------------------------------------
`include "kmer_coverage_min_sd_window_defines.svh"

module kmer_coverage_min_sd_window #(
  parameter int MAX_COUNTS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // count beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // kmer_count
  input  logic [1:0]  s_axis_tuser_i,   // head_open, tail_open
  input  logic        s_axis_tlast_i,   // last_count
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // position, window_start, window_mean, window_sd
  output logic        m_axis_tuser_o,   // is_summary
  output logic        m_axis_tlast_o    // last_result
);
  import kcmsw_pkg::*;

  logic [KLEN_W-1:0] kmer_length_q;
  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_wr;

  // register file: kmer_length only, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KMER_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KLEN_W'(31);
    end else if (cfg_wr) begin
      kmer_length_q <= pwdata[KLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KMER_LENGTH) ? {{(32-KLEN_W){1'b0}}, kmer_length_q} : '0;

  // sequencer: owns the input handshake, drives the datapath by commands
  kcmsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, accumulators, divider, square root and output register
  kcmsw_datapath #(
    .MAX_COUNTS (MAX_COUNTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .count_i       (s_axis_tdata_i),
    .flags_i       (s_axis_tuser_i),
    .kmer_length_i (kmer_length_q),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tuser_o     (m_axis_tuser_o),
    .m_tlast_o     (m_axis_tlast_o)
  );

  // loading and result delivery never overlap
  `KCMSW_ASSERT(a_no_overlap, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o), "load during output")
  // after the summary beat the block is ready for a new sequence
  `KCMSW_ASSERT(a_ready_after_sum, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> ##1 s_axis_tready_o, "not ready after summary")
  // reset holds the result channel empty
  `KCMSW_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid_o, "valid during reset")

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// kmer coverage min sd window testbench
// loads count sequences over the stream port, predicts the per-position
// minimum-sd windows and the minimum-mean summary, checks every result beat
// ----------------------------------------------------------------------------
module tb_top;
  import kcmsw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_DEPTH = 48;
  localparam int          WATCHDOG    = 100000;
  localparam int          DRAIN_WAIT  = 60;
  localparam logic [2:0]  ADDR_KLEN   = {REG_KMER_LENGTH, 2'b00};

  typedef struct {
    logic [23:0] count;
    logic        head_open;
    logic        tail_open;
    logic        last;
  } count_beat_t;

  typedef struct {
    logic        summary;
    logic [5:0]  position;
    logic [5:0]  start;
    logic [31:0] mean;
    logic [31:0] sd;
    logic        last;
  } cov_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid, m_tready;
  logic [79:0] m_tdata;
  logic        m_tuser, m_tlast;

  kmer_coverage_min_sd_window dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // kmer_count
    .s_axis_tuser_i  (s_tuser),   // head_open, tail_open
    .s_axis_tlast_i  (s_tlast),   // last_count
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // position, window_start, window_mean, window_sd
    .m_axis_tuser_o  (m_tuser),   // is_summary
    .m_axis_tlast_o  (m_tlast)    // last_result
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  count_beat_t pending_counts[$];
  cov_res_t    expected_cov[$];
  int          fail_count = 0;
  int          stall_cycles = 0;
  int          items_sent = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;

  // ---------------------------------------------------------------------------
  // coverage predictor: own copy of the sequence state and kmer_length
  // ---------------------------------------------------------------------------
  logic [23:0] seq_counts[STORE_DEPTH];
  int unsigned seq_len;
  logic [1:0]  seq_trim;
  cov_res_t    min_mean;
  logic [5:0]  klen_reg;

  function automatic int unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic void win_stats(int unsigned s, int unsigned len,
                                    output logic [31:0] mean, output logic [31:0] sd);
    longint unsigned sum, sumsq, c, num, den, q, r, v;
    sum = 0;
    sumsq = 0;
    for (int i = 0; i < len; i++) begin
      c      = seq_counts[(s + i) % STORE_DEPTH];
      sum   += c;
      sumsq += c * c;
    end
    mean = 32'((sum << 8) / len);
    num  = len * sumsq - sum * sum;
    den  = len * len;
    q    = num / den;
    r    = num % den;
    v    = (q << 16) + ((r << 16) / den);
    sd   = int_sqrt(v);
  endfunction

  function automatic void clear_seq();
    foreach (seq_counts[i]) seq_counts[i] = '0;
    seq_len  = 0;
    seq_trim = '0;
    min_mean = '{1'b0, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'd0, 1'b0};
  endfunction

  // absorb one accepted count beat, queue whatever results it causes
  function automatic void absorb_count(count_beat_t b);
    int unsigned k, head, tail, lo, len;
    longint unsigned sum;
    logic [31:0] m, d;
    cov_res_t best;
    logic have;
    if (seq_len == 0) seq_trim = {b.tail_open, b.head_open};
    if (seq_len < STORE_DEPTH) begin
      seq_counts[seq_len] = b.count;
      seq_len++;
    end
    if (!b.last) return;
    k = klen_reg;
    if (k == 0) k = 1;
    if (k > 32) k = 32;
    head = seq_trim[0] ? k - 1 : 0;
    tail = seq_trim[1] ? k : 0;
    if (seq_len > head + tail) begin
      for (int unsigned p = head; p < seq_len - tail; p++) begin
        lo   = (p + 1 > k) ? p + 1 - k : 0;
        best = '{1'b0, 6'(p), 6'(lo), 32'd0, 32'd0, 1'b0};
        have = 1'b0;
        for (int unsigned s = lo; s <= p; s++) begin
          len = p + 1;
          if (k < len) len = k;
          if (seq_len - s < len) len = seq_len - s;
          win_stats(s, len, m, d);
          // earliest window wins a tie
          if (!have || d < best.sd) begin
            best.start = 6'(s);
            best.mean  = m;
            best.sd    = d;
            have       = 1'b1;
          end
        end
        expected_cov.push_back(best);
        if (best.mean < min_mean.mean) min_mean = best;
      end
    end else begin
      // trims swallow everything: summary carries the mean of all counts
      sum = 0;
      for (int unsigned i = 0; i < seq_len; i++) sum += seq_counts[i];
      min_mean.position = '0;
      min_mean.start    = '0;
      min_mean.sd       = '0;
      min_mean.mean     = seq_len ? 32'((sum << 8) / seq_len) : 32'd0;
    end
    min_mean.summary = 1'b1;
    min_mean.last    = 1'b1;
    expected_cov.push_back(min_mean);
    clear_seq();
  endfunction

  // ---------------------------------------------------------------------------
  // count beat driver: changes at the falling edge, one gap draw per beat
  // ---------------------------------------------------------------------------
  logic s_acc, m_acc;
  int   tx_gap, rx_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_acc <= 1'b0;
      m_acc <= 1'b0;
    end else begin
      s_acc <= s_tvalid && s_tready;
      m_acc <= m_tvalid && m_tready;
    end
  end

  always @(negedge clk_i) begin
    count_beat_t b;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (s_tvalid && !s_acc) begin
      // beat still waiting for tready
    end else if (tx_gap > 0) begin
      s_tvalid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (pending_counts.size() > 0) begin
      b = pending_counts.pop_front();
      s_tdata  <= b.count;
      s_tuser  <= {b.tail_open, b.head_open};
      s_tlast  <= b.last;
      s_tvalid <= 1'b1;
      tx_gap   <= tx_idle_on ? $urandom_range(0, 9) : 0;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result side: tready held low for a random wait after each accepted beat
  always @(negedge clk_i) begin
    int w;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_acc) begin
      w = rx_idle_on ? $urandom_range(0, 9) : 0;
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted counts, compare accepted result beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cov_res_t e;
    if (rst_ni) begin
      if (s_tvalid && s_tready)
        absorb_count('{s_tdata, s_tuser[0], s_tuser[1], s_tlast});
      if (m_tvalid && m_tready) begin
        if (expected_cov.size() == 0) begin
          $display("%0t: unexpected result beat, actual data %h user %b last %b",
                   $realtime, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          e = expected_cov.pop_front();
          if (m_tuser !== e.summary || m_tdata[5:0] !== e.position ||
              m_tdata[11:6] !== e.start || m_tdata[43:12] !== e.mean ||
              m_tdata[75:44] !== e.sd || m_tlast !== e.last) begin
            $display("%0t: result mismatch expected summ %b pos %0d start %0d mean %h sd %h last %b",
                     $realtime, e.summary, e.position, e.start, e.mean, e.sd, e.last);
            $display("%0t:                 actual summ %b pos %0d start %0d mean %h sd %h last %b",
                     $realtime, m_tuser, m_tdata[5:0], m_tdata[11:6], m_tdata[43:12],
                     m_tdata[75:44], m_tlast);
            fail_count++;
          end
        end
      end
      // watchdog over cycles with no beat on either side
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic write_klen(logic [5:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_KLEN;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    klen_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender holds off until every expected result is back, then lets the
  // block finish any work that has no result behind it
  task automatic drain();
    wait (pending_counts.size() == 0 && !s_tvalid);
    wait (expected_cov.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // style: 0 full-width random, 1 small values (ties), 2 extremes only
  task automatic push_seq(int n, logic head, logic tail, int style);
    count_beat_t b;
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       b.count = 24'($urandom);
        1:       b.count = 24'($urandom_range(0, 7));
        default: b.count = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
      endcase
      // trim bits on later beats must be ignored
      b.head_open = (i == 0) ? head : 1'($urandom);
      b.tail_open = (i == 0) ? tail : 1'($urandom);
      b.last      = (i == n - 1);
      pending_counts.push_back(b);
    end
    items_sent += n;
  endtask

  task automatic run_seq(logic [5:0] k, int n, logic head, logic tail, int style);
    write_klen(k);
    push_seq(n, head, tail, style);
    drain();
  endtask

  initial begin
    int n, kk;
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    klen_reg = 6'd31;
    clear_seq();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset k with a fully trimmed run, single count, max count,
    // head and tail trims, trims covering all, flat counts for ties
    push_seq(3, 1'b1, 1'b1, 0);
    drain();
    run_seq(6'd1, 1, 1'b0, 1'b0, 2);
    run_seq(6'd1, 3, 1'b1, 1'b1, 2);
    run_seq(6'd2, 2, 1'b1, 1'b1, 0);
    run_seq(6'd2, 4, 1'b0, 1'b0, 1);
    run_seq(6'd0, 3, 1'b1, 1'b0, 2);
    run_seq(6'd3, 5, 1'b0, 1'b1, 2);

    // store overflow: later counts are dropped, tlast still ends the run
    tx_idle_on = 1'b0;
    run_seq(6'd2, 52, 1'b1, 1'b0, 0);
    tx_idle_on = 1'b1;
    // largest k: clipped value, fully covered run, and one long open run
    run_seq(6'd63, 34, 1'b1, 1'b1, 0);
    rx_idle_on = 1'b0;
    run_seq(6'd32, 33, 1'b0, 1'b0, 1);
    rx_idle_on = 1'b1;

    while (items_sent < 250) begin
      kk = $urandom_range(0, 9);
      n  = $urandom_range(1, 8);
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      run_seq((kk > 6) ? 6'($urandom_range(0, 63)) : 6'(kk), n,
              1'($urandom), 1'($urandom), $urandom_range(0, 2));
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/kcmsw_pkg.sv
sv/kcmsw_ram.sv
sv/kcmsw_datapath.sv
sv/kcmsw_ctrl.sv
sv/kmer_coverage_min_sd_window.sv
tb/sv/tb_top.sv
